@@ hw/rtl/dwrb_pkg.sv @@
// Package for the draw-without-replacement bag: sizes, widths and the sequencer state type.
// Used by the channel interfaces and the top level; depends on nothing else.
`timescale 1ns / 1ps

package dwrb_pkg;

   localparam int POOL_DEPTH = 1024;
   localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(POOL_DEPTH + 1);
   localparam int SIZE_W     = 11;
   localparam int INDEX_W    = 10;
   localparam int WORD_W     = 32;
   localparam int STEP_W     = $clog2(WORD_W);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_REFILL    = 6'b000010,
      ST_DIVIDE    = 6'b000100,
      ST_READ_SLOT = 6'b001000,
      ST_READ_LAST = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

endpackage

@@ hw/rtl/dwrb_channels.sv @@
// Valid/ready channel interfaces for the draw-without-replacement bag.
// Depends on dwrb_pkg for the payload widths.
`timescale 1ns / 1ps

interface dwrb_req_if import dwrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

interface dwrb_rsp_if import dwrb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] drawn_index;
   logic               round_done;

   modport source (output valid, output drawn_index, output round_done, input ready);
   modport sink (input valid, input drawn_index, input round_done, output ready);
endinterface

interface dwrb_csr_if import dwrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] pool_size;

   modport source (output valid, output pool_size, input ready);
   modport sink (input valid, input pool_size, output ready);
endinterface

@@ hw/rtl/draw_without_replacement_bag.sv @@
// Top level of the draw-without-replacement bag: sequencer, restoring divider and pool RAM.
// Depends on dwrb_pkg, the channel interfaces in dwrb_channels.sv and dwrb_ram.
`timescale 1ns / 1ps

// Usage:
// Each req beat carries a 32-bit random word and yields exactly one rsp beat with
// the drawn index and a flag on the draw that empties the pool. The csr channel
// writes pool_size (zero acts as one, values above the pool depth saturate) and
// clears the remaining count, so the next draw starts a fresh round. csr is
// always ready; write it only while no draw is in flight.
// Operation: a draw runs the restoring divider (one remainder bit per
// cycle, random word mod remaining count), then two RAM reads and a write-back.
// The first draw of a round also walks the pool RAM once to refill it, one entry
// per cycle, up to the effective pool size.
// req is ready only while the sequencer is idle, so one draw is handled at a time.
// The result sits in an output register; a new draw may be accepted while it waits.
// If the receiver stalls, a finished draw holds at write-back until the register frees.
// Reset sets pool_size to the full depth and the remaining count to zero, so the
// first draw refills the pool. Pool RAM contents need no reset.

module draw_without_replacement_bag import dwrb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dwrb_req_if.sink    req_bus,
   dwrb_rsp_if.source  rsp_bus,
   dwrb_csr_if.sink    csr_bus
);

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   pool_size_ff, pool_size_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0]   refill_k_ff, refill_k_in;
   logic [WORD_W-1:0]   dividend_ff, dividend_in;
   logic [COUNT_W:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [INDEX_W-1:0]  picked_ff, picked_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  drawn_index_ff, drawn_index_in;
   logic                round_done_ff, round_done_in;

   logic [COUNT_W-1:0]  eff_size;
   logic [COUNT_W-1:0]  count_dec;
   logic [COUNT_W:0]    rem_shift;
   logic                req_fire;
   logic                out_load;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [INDEX_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [INDEX_W-1:0]  ram_rd_data;

   dwrb_ram #(
      .WIDTH (INDEX_W),
      .DEPTH (POOL_DEPTH)
   ) u_pool (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.drawn_index = drawn_index_ff;
   assign rsp_bus.round_done  = round_done_ff;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);
   assign count_dec = count_ff - COUNT_W'(1);
   assign rem_shift = {rem_ff[COUNT_W-1:0], dividend_ff[WORD_W-1]};

   always_comb begin
      if (pool_size_ff == '0) begin
         eff_size = COUNT_W'(1);
      end else if (32'(pool_size_ff) > 32'(POOL_DEPTH)) begin
         eff_size = COUNT_W'(POOL_DEPTH);
      end else begin
         eff_size = COUNT_W'(pool_size_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      pool_size_in   = pool_size_ff;
      count_in       = count_ff;
      refill_k_in    = refill_k_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      picked_in      = picked_ff;
      rsp_valid_in   = rsp_valid_ff;
      drawn_index_in = drawn_index_ff;
      round_done_in  = round_done_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = refill_k_ff;
      ram_wr_data    = INDEX_W'(refill_k_ff);
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rem_ff[ADDR_W-1:0];

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               dividend_in = req_bus.random_word;
               rem_in      = '0;
               step_in     = '0;
               refill_k_in = '0;
               state_in    = (count_ff == '0) ? ST_REFILL : ST_DIVIDE;
            end
         end
         ST_REFILL: begin
            ram_wr_en = 1'b1;
            if (COUNT_W'(refill_k_ff) == eff_size - COUNT_W'(1)) begin
               count_in = eff_size;
               state_in = ST_DIVIDE;
            end else begin
               refill_k_in = refill_k_ff + ADDR_W'(1);
            end
         end
         ST_DIVIDE: begin
            // Restoring step: bring in the next dividend bit and subtract if it fits.
            if (rem_shift >= {1'b0, count_ff}) begin
               rem_in = rem_shift - {1'b0, count_ff};
            end else begin
               rem_in = rem_shift;
            end
            dividend_in = {dividend_ff[WORD_W-2:0], 1'b0};
            step_in     = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(WORD_W - 1)) begin
               state_in = ST_READ_SLOT;
            end
         end
         ST_READ_SLOT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rem_ff[ADDR_W-1:0];
            state_in    = ST_READ_LAST;
         end
         ST_READ_LAST: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = count_dec[ADDR_W-1:0];
            picked_in   = ram_rd_data;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // The last live entry fills the drawn slot once the result can be loaded.
            if (out_load) begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = rem_ff[ADDR_W-1:0];
               ram_wr_data    = ram_rd_data;
               count_in       = count_dec;
               rsp_valid_in   = 1'b1;
               drawn_index_in = picked_ff;
               round_done_in  = (count_dec == '0);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_bus.valid && csr_bus.ready) begin
         pool_size_in = csr_bus.pool_size;
         count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pool_size_ff <= SIZE_W'(1024);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_size_ff <= pool_size_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      refill_k_ff    <= refill_k_in;
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      picked_ff      <= picked_in;
      drawn_index_ff <= drawn_index_in;
      round_done_ff  <= round_done_in;
   end

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(POOL_DEPTH))
      else $error("remaining count exceeds pool depth");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ_SLOT) |-> (rem_ff < {1'b0, count_ff}) && (count_ff != '0))
      else $error("divider remainder not below remaining count");

   a_done_matches_count: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_bus.valid && (rsp_bus.round_done == (count_ff == '0)))
      else $error("round_done disagrees with remaining count");
`endif

endmodule

@@ hw/rtl/dwrb_ram.sv @@
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module dwrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
